// ===== rtl/assert_macros.svh =====
// Assertion helpers; the user module provides clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define AST_CHK_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ast check failed");
`define AST_CHK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ast check failed");
`endif

// ===== rtl/ast_pkg.sv =====
package ast_pkg;
  localparam int MAX_TIMES_DEF  = 256;
  localparam int MAX_ANGLES_DEF = 64;
  localparam int DW = 98;
  localparam logic [31:0] PI_Q30 = 32'd3373259426;
  localparam logic [8:0] TIME_COUNT_RST  = 9'd256;
  localparam logic [6:0] ANGLE_COUNT_RST = 7'd64;
  localparam logic REG_TIME_COUNT  = 1'b0;
  localparam logic REG_ANGLE_COUNT = 1'b1;
  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_ANGLE  = 2'd1;
  localparam logic [1:0] STAT_BEYOND = 2'd2;

  typedef enum logic [1:0] {
    OP_LOAD_ANGLE, OP_LOAD_TIME, OP_LOAD_RADIUS, OP_QUERY
  } opcode_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_AFIRST, ST_ALAST, ST_ACHK, ST_ASRCH, ST_AMID, ST_WSET, ST_WDIV,
    ST_PREP, ST_EV_T, ST_EV_R1, ST_EV_R2, ST_EV_M1, ST_EV_M2S, ST_EV_M2,
    ST_DECIDE, ST_TSRCH, ST_FIN, ST_QDIV, ST_QMUL
  } state_t;

  typedef enum logic [1:0] {PH_FIRST, PH_LAST, PH_MID} phase_t;

  typedef struct packed {
    logic        go;
    logic [63:0] a;
    logic [32:0] b;
  } mul_req_t;

  typedef struct packed {
    logic        done;
    logic [95:0] p;
  } mul_rsp_t;

  typedef struct packed {
    logic          go;
    logic [DW-1:0] num;
    logic [DW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quot;
  } div_rsp_t;
endpackage

// ===== rtl/arrival_surface_time_solver_unit.sv =====
// Loads keep the unit idle and give no result; an angle error strobes in the next cycle.
// A query holds busy through at most sa = ceil(log2(angle_count - 1)) angle search steps
// and p = 2 + ceil(log2(time_count - 1)) time probes; a probe without angle interpolation
// is shorter, and early exits end sooner.
// The result strobes in the first idle cycle, which may accept the next item; no stall.
// Synchronous reset clears control, sets time_count 256, angle_count 64; tables stay unknown.
module arrival_surface_time_solver_unit #(
  parameter int MAX_TIMES  = ast_pkg::MAX_TIMES_DEF,
  parameter int MAX_ANGLES = ast_pkg::MAX_ANGLES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_opcode,
  input  logic [5:0]         in_angle_slot,
  input  logic [7:0]         in_time_slot,
  input  logic [63:0]        in_load_value,
  input  logic signed [31:0] in_view_cosine,
  input  logic [63:0]        in_observed_time,
  input  logic [31:0]        in_polar_angle,
  output logic               out_strobe,
  output logic [63:0]        out_solved_time,
  output logic [7:0]         out_lower_time_index,
  output logic [7:0]         out_upper_time_index,
  output logic [1:0]         out_status,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  localparam int AIW    = (MAX_ANGLES > 1) ? $clog2(MAX_ANGLES) : 1;
  localparam int TIW    = $clog2(MAX_TIMES);
  localparam int RDEPTH = MAX_ANGLES * MAX_TIMES;
  localparam int RIW    = $clog2(RDEPTH);
  localparam int DW     = ast_pkg::DW;

  logic [31:0] ag_mem [MAX_ANGLES];
  logic [63:0] tg_mem [MAX_TIMES];
  logic [63:0] rt_mem [RDEPTH];

  ast_pkg::state_t state_r, state_nxt;
  ast_pkg::phase_t phase_r, phase_nxt;

  logic [8:0]  time_count_r;
  logic [6:0]  angle_count_r;
  logic [31:0] theta_r, theta_nxt, mag_r, mag_nxt, alo_r, alo_nxt, ahi_r, ahi_nxt;
  logic [63:0] tobs_r, tobs_nxt, tk_r, tk_nxt, r_r, r_nxt;
  logic [63:0] tlo_r, tlo_nxt, thi_r, thi_nxt;
  logic        neg_r, neg_nxt, up_r, up_nxt;
  logic [AIW-1:0] a1_r, a1_nxt, a2_r, a2_nxt;
  logic [32:0] w_r, w_nxt;
  logic [TIW-1:0] k_r, k_nxt, lo_r, lo_nxt, hi_r, hi_nxt;
  logic [DW-1:0] d1_r, d1_nxt, d2_r, d2_nxt, dcur_r, dcur_nxt;
  logic        ostr_r, ostr_nxt;
  logic [63:0] osol_r, osol_nxt;
  logic [7:0]  olo_r, olo_nxt, ohi_r, ohi_nxt;
  logic [1:0]  ost_r, ost_nxt;

  logic [31:0] ag_rdata_r;
  logic [63:0] tg_rdata_r, rt_rdata_r;
  logic [AIW-1:0] ag_raddr, amid, na_m1, a_sel;
  logic [RIW-1:0] rt_raddr;
  logic [TIW-1:0] nt_m1, tmid;

  ast_pkg::mul_req_t mreq;
  ast_pkg::mul_rsp_t mrsp;
  ast_pkg::div_req_t dreq;
  ast_pkg::div_rsp_t drsp;

  logic acc, is_query, theta_bad, below, above, amore, w_ok, w_full, lerp_need;
  logic d_pos, d_neg, tmore, d1_zero, d2_zero, cfg_we;
  logic [31:0] wnum, wden, wnum_c;
  logic [63:0] part;

  assign busy     = (state_r != ast_pkg::ST_IDLE);
  assign acc      = start && !busy;
  assign is_query = (in_opcode == ast_pkg::OP_QUERY);
  assign theta_bad = in_polar_angle > ast_pkg::PI_Q30;

  // register file
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;
  always_comb begin
    unique case (paddr[2])
      ast_pkg::REG_TIME_COUNT:  prdata = 32'(time_count_r);
      ast_pkg::REG_ANGLE_COUNT: prdata = 32'(angle_count_r);
      default:                  prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_count_r  <= ast_pkg::TIME_COUNT_RST;
      angle_count_r <= ast_pkg::ANGLE_COUNT_RST;
    end else if (cfg_we) begin
      if (paddr[2] == ast_pkg::REG_TIME_COUNT) time_count_r <= pwdata[8:0];
      else angle_count_r <= pwdata[6:0];
    end
  end

  always_comb begin
    if (angle_count_r == 7'd0) na_m1 = '0;
    else if (32'(angle_count_r) > MAX_ANGLES) na_m1 = AIW'(MAX_ANGLES - 1);
    else na_m1 = AIW'(angle_count_r - 7'd1);
    if (time_count_r < 9'd2) nt_m1 = TIW'(1);
    else if (32'(time_count_r) > MAX_TIMES) nt_m1 = TIW'(MAX_TIMES - 1);
    else nt_m1 = TIW'(time_count_r - 9'd1);
  end

  // tables
  always_comb begin
    unique case (state_r)
      ast_pkg::ST_ALAST: ag_raddr = na_m1;
      ast_pkg::ST_ASRCH: ag_raddr = amid;
      default:           ag_raddr = '0;
    endcase
  end
  assign a_sel    = (state_r == ast_pkg::ST_EV_R1) ? a2_r : a1_r;
  assign rt_raddr = RIW'(a_sel) * RIW'(MAX_TIMES) + RIW'(k_r);

  always_ff @(posedge clk) begin
    if (acc && in_opcode == ast_pkg::OP_LOAD_ANGLE && 32'(in_angle_slot) < MAX_ANGLES)
      ag_mem[AIW'(in_angle_slot)] <= in_load_value[31:0];
    ag_rdata_r <= ag_mem[ag_raddr];
  end

  always_ff @(posedge clk) begin
    if (acc && in_opcode == ast_pkg::OP_LOAD_TIME && 32'(in_time_slot) < MAX_TIMES)
      tg_mem[TIW'(in_time_slot)] <= in_load_value;
    tg_rdata_r <= tg_mem[k_r];
  end

  always_ff @(posedge clk) begin
    if (acc && in_opcode == ast_pkg::OP_LOAD_RADIUS && 32'(in_angle_slot) < MAX_ANGLES
        && 32'(in_time_slot) < MAX_TIMES)
      rt_mem[RIW'(in_angle_slot) * RIW'(MAX_TIMES) + RIW'(in_time_slot)] <= in_load_value;
    rt_rdata_r <= rt_mem[rt_raddr];
  end

  // shared units
  ast_mul u_mul (.clk(clk), .rst_n(rst_n), .req(mreq), .rsp(mrsp));
  ast_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  // decision terms
  assign amid   = AIW'(({1'b0, a1_r} + {1'b0, a2_r}) >> 1);
  assign tmid   = TIW'(({1'b0, lo_r} + {1'b0, hi_r}) >> 1);
  assign amore  = ({1'b0, a2_r} - {1'b0, a1_r}) > (AIW+1)'(1);
  assign tmore  = ({1'b0, hi_r} - {1'b0, lo_r}) > (TIW+1)'(1);
  assign below  = theta_r < alo_r;
  assign above  = theta_r > ag_rdata_r;
  assign w_ok   = (a1_r != a2_r) && (ahi_r > alo_r) && (theta_r >= alo_r);
  assign wnum   = theta_r - alo_r;
  assign wden   = ahi_r - alo_r;
  assign wnum_c = (wnum > wden) ? wden : wnum;
  assign w_full = (wnum_c == wden);
  assign lerp_need = (a1_r != a2_r) && (w_r != 33'd0);
  assign d_neg  = dcur_r[DW-1];
  assign d_pos  = !dcur_r[DW-1] && (dcur_r != '0);
  assign d1_zero = (d1_r == '0);
  assign d2_zero = (d2_r == '0);
  assign part   = mrsp.p[95:32];

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ast_pkg::ST_IDLE:   if (acc && is_query && !theta_bad) state_nxt = ast_pkg::ST_AFIRST;
      ast_pkg::ST_AFIRST: state_nxt = ast_pkg::ST_ALAST;
      ast_pkg::ST_ALAST:  state_nxt = ast_pkg::ST_ACHK;
      ast_pkg::ST_ACHK:   state_nxt = (below || above) ? ast_pkg::ST_PREP : ast_pkg::ST_ASRCH;
      ast_pkg::ST_ASRCH:  state_nxt = amore ? ast_pkg::ST_AMID : ast_pkg::ST_WSET;
      ast_pkg::ST_AMID:   state_nxt = ast_pkg::ST_ASRCH;
      ast_pkg::ST_WSET:   state_nxt = (w_ok && !w_full) ? ast_pkg::ST_WDIV : ast_pkg::ST_PREP;
      ast_pkg::ST_WDIV:   if (drsp.done) state_nxt = ast_pkg::ST_PREP;
      ast_pkg::ST_PREP:   state_nxt = ast_pkg::ST_EV_T;
      ast_pkg::ST_EV_T:   state_nxt = ast_pkg::ST_EV_R1;
      ast_pkg::ST_EV_R1:  state_nxt = lerp_need ? ast_pkg::ST_EV_R2 : ast_pkg::ST_EV_M2S;
      ast_pkg::ST_EV_R2:  state_nxt = ast_pkg::ST_EV_M1;
      ast_pkg::ST_EV_M1:  if (mrsp.done) state_nxt = ast_pkg::ST_EV_M2S;
      ast_pkg::ST_EV_M2S: state_nxt = ast_pkg::ST_EV_M2;
      ast_pkg::ST_EV_M2:  if (mrsp.done) state_nxt = ast_pkg::ST_DECIDE;
      ast_pkg::ST_DECIDE: begin
        unique case (phase_r)
          ast_pkg::PH_FIRST: state_nxt = d_pos ? ast_pkg::ST_IDLE : ast_pkg::ST_EV_T;
          ast_pkg::PH_LAST:  state_nxt = d_neg ? ast_pkg::ST_IDLE : ast_pkg::ST_TSRCH;
          default:           state_nxt = ast_pkg::ST_TSRCH;
        endcase
      end
      ast_pkg::ST_TSRCH:  state_nxt = tmore ? ast_pkg::ST_EV_T : ast_pkg::ST_FIN;
      ast_pkg::ST_FIN:    state_nxt = (d1_zero || d2_zero) ? ast_pkg::ST_IDLE : ast_pkg::ST_QDIV;
      ast_pkg::ST_QDIV:   if (drsp.done) state_nxt = ast_pkg::ST_QMUL;
      ast_pkg::ST_QMUL:   if (mrsp.done) state_nxt = ast_pkg::ST_IDLE;
      default:            state_nxt = ast_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    phase_nxt = phase_r;
    theta_nxt = theta_r; tobs_nxt = tobs_r; mag_nxt = mag_r; neg_nxt = neg_r;
    alo_nxt = alo_r; ahi_nxt = ahi_r; a1_nxt = a1_r; a2_nxt = a2_r; w_nxt = w_r;
    k_nxt = k_r; lo_nxt = lo_r; hi_nxt = hi_r; tk_nxt = tk_r; r_nxt = r_r;
    tlo_nxt = tlo_r; thi_nxt = thi_r; up_nxt = up_r;
    d1_nxt = d1_r; d2_nxt = d2_r; dcur_nxt = dcur_r;
    ostr_nxt = 1'b0; osol_nxt = osol_r; olo_nxt = olo_r; ohi_nxt = ohi_r; ost_nxt = ost_r;
    mreq = '0;
    dreq = '0;
    unique case (state_r)
      ast_pkg::ST_IDLE: begin
        if (acc && is_query) begin
          theta_nxt = in_polar_angle;
          tobs_nxt  = in_observed_time;
          neg_nxt   = in_view_cosine[31];
          mag_nxt   = in_view_cosine[31] ? (~in_view_cosine + 32'd1) : in_view_cosine;
          if (theta_bad) begin
            ostr_nxt = 1'b1; osol_nxt = 64'd0; olo_nxt = 8'd0; ohi_nxt = 8'd0;
            ost_nxt  = ast_pkg::STAT_ANGLE;
          end
        end
      end
      ast_pkg::ST_ALAST: alo_nxt = ag_rdata_r;
      ast_pkg::ST_ACHK: begin
        w_nxt = 33'd0;
        if (below) begin
          a1_nxt = '0; a2_nxt = '0;
        end else if (above) begin
          a1_nxt = na_m1; a2_nxt = na_m1;
        end else begin
          a1_nxt = '0; a2_nxt = na_m1; ahi_nxt = ag_rdata_r;
        end
      end
      ast_pkg::ST_AMID: begin
        if (ag_rdata_r > theta_r) begin
          a2_nxt = amid; ahi_nxt = ag_rdata_r;
        end else begin
          a1_nxt = amid; alo_nxt = ag_rdata_r;
        end
      end
      ast_pkg::ST_WSET: begin
        if (!w_ok) w_nxt = 33'd0;
        else if (w_full) w_nxt = 33'h1_0000_0000;
        else begin
          dreq.go = 1'b1; dreq.num = DW'(wnum_c); dreq.den = DW'(wden);
        end
      end
      ast_pkg::ST_WDIV: if (drsp.done) w_nxt = {1'b0, drsp.quot};
      ast_pkg::ST_PREP: begin
        k_nxt = '0; phase_nxt = ast_pkg::PH_FIRST;
      end
      ast_pkg::ST_EV_R1: begin
        tk_nxt = tg_rdata_r; r_nxt = rt_rdata_r;
      end
      ast_pkg::ST_EV_R2: begin
        up_nxt  = rt_rdata_r >= r_r;
        mreq.go = 1'b1;
        mreq.a  = (rt_rdata_r >= r_r) ? rt_rdata_r - r_r : r_r - rt_rdata_r;
        mreq.b  = w_r;
      end
      ast_pkg::ST_EV_M1: if (mrsp.done) r_nxt = up_r ? r_r + part : r_r - part;
      ast_pkg::ST_EV_M2S: begin
        mreq.go = 1'b1; mreq.a = r_r; mreq.b = {1'b0, mag_r};
      end
      ast_pkg::ST_EV_M2: begin
        if (mrsp.done) begin
          dcur_nxt = (DW'(tk_r) << 30) - (DW'(tobs_r) << 30);
          dcur_nxt = neg_r ? dcur_nxt + DW'(mrsp.p) : dcur_nxt - DW'(mrsp.p);
        end
      end
      ast_pkg::ST_DECIDE: begin
        unique case (phase_r)
          ast_pkg::PH_FIRST: begin
            if (d_pos) begin
              ostr_nxt = 1'b1; osol_nxt = tk_r; olo_nxt = 8'd0; ohi_nxt = 8'd0;
              ost_nxt  = ast_pkg::STAT_OK;
            end else begin
              d1_nxt = dcur_r; tlo_nxt = tk_r; k_nxt = nt_m1; phase_nxt = ast_pkg::PH_LAST;
            end
          end
          ast_pkg::PH_LAST: begin
            if (d_neg) begin
              ostr_nxt = 1'b1; osol_nxt = 64'd0; olo_nxt = 8'd0; ohi_nxt = 8'd0;
              ost_nxt  = ast_pkg::STAT_BEYOND;
            end else begin
              d2_nxt = dcur_r; thi_nxt = tk_r; lo_nxt = '0; hi_nxt = nt_m1;
            end
          end
          default: begin
            if (d_pos) begin
              hi_nxt = k_r; d2_nxt = dcur_r; thi_nxt = tk_r;
            end else begin
              lo_nxt = k_r; d1_nxt = dcur_r; tlo_nxt = tk_r;
            end
          end
        endcase
      end
      ast_pkg::ST_TSRCH: begin
        if (tmore) begin
          k_nxt = tmid; phase_nxt = ast_pkg::PH_MID;
        end
      end
      ast_pkg::ST_FIN: begin
        if (d1_zero || d2_zero) begin
          ostr_nxt = 1'b1; osol_nxt = d1_zero ? tlo_r : thi_r;
          olo_nxt  = 8'(lo_r); ohi_nxt = 8'(hi_r); ost_nxt = ast_pkg::STAT_OK;
        end else begin
          dreq.go = 1'b1; dreq.num = '0 - d1_r; dreq.den = d2_r - d1_r;
        end
      end
      ast_pkg::ST_QDIV: begin
        if (drsp.done) begin
          up_nxt  = thi_r >= tlo_r;
          mreq.go = 1'b1;
          mreq.a  = (thi_r >= tlo_r) ? thi_r - tlo_r : tlo_r - thi_r;
          mreq.b  = {1'b0, drsp.quot};
        end
      end
      ast_pkg::ST_QMUL: begin
        if (mrsp.done) begin
          ostr_nxt = 1'b1; osol_nxt = up_r ? tlo_r + part : tlo_r - part;
          olo_nxt  = 8'(lo_r); ohi_nxt = 8'(hi_r); ost_nxt = ast_pkg::STAT_OK;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ast_pkg::ST_IDLE;
      phase_r <= ast_pkg::PH_FIRST;
      ostr_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      ostr_r  <= ostr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    theta_r <= theta_nxt; tobs_r <= tobs_nxt; mag_r <= mag_nxt; neg_r <= neg_nxt;
    alo_r <= alo_nxt; ahi_r <= ahi_nxt; a1_r <= a1_nxt; a2_r <= a2_nxt; w_r <= w_nxt;
    k_r <= k_nxt; lo_r <= lo_nxt; hi_r <= hi_nxt; tk_r <= tk_nxt; r_r <= r_nxt;
    tlo_r <= tlo_nxt; thi_r <= thi_nxt; up_r <= up_nxt;
    d1_r <= d1_nxt; d2_r <= d2_nxt; dcur_r <= dcur_nxt;
    osol_r <= osol_nxt; olo_r <= olo_nxt; ohi_r <= ohi_nxt; ost_r <= ost_nxt;
  end

  assign out_strobe           = ostr_r;
  assign out_solved_time      = osol_r;
  assign out_lower_time_index = olo_r;
  assign out_upper_time_index = ohi_r;
  assign out_status           = ost_r;
endmodule

// ===== rtl/ast_mul.sv =====
// 64 x 33 multiply from two 32 x 32 partial products; b is at most 2^32.
module ast_mul (
  input  logic             clk,
  input  logic             rst_n,
  input  ast_pkg::mul_req_t req,
  output ast_pkg::mul_rsp_t rsp
);
  logic [1:0]  cnt_r;
  logic [63:0] a_r;
  logic [32:0] b_r;
  logic [63:0] pp0_r, pp1_r;
  logic [95:0] p_r;
  logic        done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= 2'd0;
      done_r <= 1'b0;
    end else begin
      done_r <= (cnt_r == 2'd3);
      if (req.go) begin
        cnt_r <= 2'd1;
      end else if (cnt_r != 2'd0) begin
        cnt_r <= cnt_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.go) begin
      a_r <= req.a;
      b_r <= req.b;
    end
    if (cnt_r == 2'd1) pp0_r <= a_r[31:0] * b_r[31:0];
    if (cnt_r == 2'd2) pp1_r <= a_r[63:32] * b_r[31:0];
    if (cnt_r == 2'd3) begin
      p_r <= b_r[32] ? {a_r, 32'd0} : (96'(pp0_r) + {pp1_r, 32'd0});
    end
  end

  assign rsp.done = done_r;
  assign rsp.p    = p_r;
endmodule

// ===== rtl/ast_div.sv =====
// Restoring divider, 32 quotient bits of num * 2^32 / den, one bit a cycle; num < den.
module ast_div (
  input  logic             clk,
  input  logic             rst_n,
  input  ast_pkg::div_req_t req,
  output ast_pkg::div_rsp_t rsp
);
  logic [5:0]            cnt_r;
  logic                  done_r;
  logic [ast_pkg::DW-1:0] rem_r, den_r, rem_sh;
  logic [31:0]           q_r;
  logic                  take;

  assign rem_sh = {rem_r[ast_pkg::DW-2:0], 1'b0};
  assign take   = rem_sh >= den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= 6'd0;
      done_r <= 1'b0;
    end else begin
      done_r <= (cnt_r == 6'd1);
      if (req.go) begin
        cnt_r <= 6'd32;
      end else if (cnt_r != 6'd0) begin
        cnt_r <= cnt_r - 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.go) begin
      rem_r <= req.num;
      den_r <= req.den;
      q_r   <= 32'd0;
    end else if (cnt_r != 6'd0) begin
      rem_r <= take ? rem_sh - den_r : rem_sh;
      q_r   <= {q_r[30:0], take};
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = q_r;
endmodule

// ===== rtl/ast_checker.sv =====
`include "assert_macros.svh"
module ast_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic [1:0]  in_opcode,
  input logic [31:0] in_polar_angle,
  input logic        out_strobe,
  input logic [63:0] out_solved_time,
  input logic [7:0]  out_lower_time_index,
  input logic [7:0]  out_upper_time_index,
  input logic [1:0]  out_status
);
  `AST_CHK_SAME(a_strobe_idle, out_strobe, !busy)
  `AST_CHK_NEXT(a_query_runs, start && !busy && in_opcode == ast_pkg::OP_QUERY, busy || out_strobe)
  `AST_CHK_NEXT(a_load_quiet, start && !busy && in_opcode != ast_pkg::OP_QUERY, !busy && !out_strobe)
  `AST_CHK_NEXT(a_angle_err, start && !busy && in_opcode == ast_pkg::OP_QUERY && in_polar_angle > ast_pkg::PI_Q30, out_strobe && out_status == ast_pkg::STAT_ANGLE)
  `AST_CHK_SAME(a_err_zero, out_strobe && out_status != ast_pkg::STAT_OK, out_solved_time == 64'd0 && out_lower_time_index == 8'd0 && out_upper_time_index == 8'd0)
endmodule

bind arrival_surface_time_solver_unit ast_checker u_ast_checker (.*);
